>>> rtl/imm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and symbol helpers for the IUPAC motif masker.
// No dependencies; used by imm_cell, iupac_motif_masker and imm_checker.
package imm_pkg;

   localparam int MAX_MOTIF_LEN = 16;
   localparam int CELL_IDX_W    = $clog2(MAX_MOTIF_LEN);
   localparam int FILL_W        = CELL_IDX_W + 1;
   localparam int SYM_W         = 4;
   localparam int MOTIF_W       = MAX_MOTIF_LEN * SYM_W;
   localparam int LEN_W         = 5;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 64;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_MOTIF_SYMBOLS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTIF_LENGTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REVCOMP_ENABLE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_CODE      = 2'd3;

   // broadcast from the top level to every window cell
   typedef struct packed {
      logic                  emit;      // oldest entry leaves, row shifts down
      logic                  load;      // an item is written this cycle
      logic [CELL_IDX_W-1:0] pos;       // write position after the shift
      logic [CELL_IDX_W-1:0] start;     // oldest position under the compare
      logic                  match_en;  // window holds a full motif length
      logic [SYM_W-1:0]      sym;       // incoming symbol
   } imm_ctl_type;

   // swap A<->T and C<->G
   function automatic logic [SYM_W-1:0] complement(input logic [SYM_W-1:0] c);
      return {c[0], c[1], c[2], c[3]};
   endfunction

   // non-empty base set contained in the motif set
   function automatic logic sym_match(input logic [SYM_W-1:0] s,
                                      input logic [SYM_W-1:0] m);
      return (s != '0) && ((s & ~m) == '0);
   endfunction

endpackage

>>> rtl/iupac_motif_masker.sv
`timescale 1ns / 1ps
// Top level of the IUPAC motif masker: control, config registers, cell row.
// Depends on imm_pkg and imm_cell.
//
//  channel | direction | ports                                         | handshake
//  req     | in        | req_symbol, req_last                          | req_valid/req_ready
//  rsp     | out       | rsp_out_symbol, rsp_masked, rsp_out_last,     | rsp_valid/rsp_ready
//          |           | rsp_any_masked                                |
//  csr     | in        | csr_index, csr_wdata                          | csr_wr_en, no wait
//
// Streaming takes one item per cycle unless rsp stalls: the window row compares all
// positions in the cycle an item is written, and the oldest entry shifts out in the
// same cycle. An item with last holds off req_ready while the row drains, one result
// per cycle unless rsp stalls, until the window (up to 16 entries) is empty. Surplus
// entries after a shortened motif leave one a cycle too, once the next item waits,
// before it is written. Results sit in one output register; reset is synchronous.
module iupac_motif_masker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [imm_pkg::SYM_W-1:0]       req_symbol,
   input  logic                            req_last,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [imm_pkg::SYM_W-1:0]       rsp_out_symbol,
   output logic                            rsp_masked,
   output logic                            rsp_out_last,
   output logic                            rsp_any_masked,
   input  logic                            csr_wr_en,
   input  logic [imm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [imm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int N = imm_pkg::MAX_MOTIF_LEN;

   logic [imm_pkg::MOTIF_W-1:0]  motif_ff, motif_in;
   logic [imm_pkg::LEN_W-1:0]    len_ff, len_in;
   logic                         rc_en_ff, rc_en_in;
   logic [imm_pkg::SYM_W-1:0]    mask_code_ff, mask_code_in;

   logic [imm_pkg::FILL_W-1:0]   fill_ff, fill_in;
   logic                         flush_ff, flush_in;
   logic                         armed_ff, armed_in;
   logic                         found_ff, found_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [imm_pkg::SYM_W-1:0]    out_symbol_ff, out_symbol_in;
   logic                         masked_ff, masked_in;
   logic                         out_last_ff, out_last_in;
   logic                         any_masked_ff, any_masked_in;

   logic [imm_pkg::LEN_W-1:0]    len_eff;
   logic                         out_free;
   logic                         emit;
   logic                         final_emit;
   logic [imm_pkg::FILL_W-1:0]   fill_e;
   logic [imm_pkg::FILL_W-1:0]   fill_n;
   logic                         accept;
   logic                         hit;
   imm_pkg::imm_ctl_type         ctl;

   logic [imm_pkg::SYM_W-1:0]    cur_sym  [N];
   logic                         cur_mask [N];
   logic [N-1:0]                 fwd_ok;
   logic [N-1:0]                 rc_ok;

   // config registers
   always_comb begin
      motif_in     = motif_ff;
      len_in       = len_ff;
      rc_en_in     = rc_en_ff;
      mask_code_in = mask_code_ff;
      if (csr_wr_en) begin
         case (csr_index)
            imm_pkg::CSR_MOTIF_SYMBOLS:  motif_in     = csr_wdata[imm_pkg::MOTIF_W-1:0];
            imm_pkg::CSR_MOTIF_LENGTH:   len_in       = csr_wdata[imm_pkg::LEN_W-1:0];
            imm_pkg::CSR_REVCOMP_ENABLE: rc_en_in     = csr_wdata[0];
            imm_pkg::CSR_MASK_CODE:      mask_code_in = csr_wdata[imm_pkg::SYM_W-1:0];
            default: ;
         endcase
      end
   end

   // control
   always_comb begin
      if (len_ff == '0) begin
         len_eff = imm_pkg::LEN_W'(1);
      end else if (len_ff > imm_pkg::LEN_W'(N)) begin
         len_eff = imm_pkg::LEN_W'(N);
      end else begin
         len_eff = len_ff;
      end

      out_free = !rsp_valid_ff || rsp_ready;
      // surplus after a shortened motif leaves only once the next item waits
      emit = out_free && (fill_ff != '0) &&
             (flush_ff || ((fill_ff >= len_eff) && (armed_ff || req_valid)));
      final_emit = emit && flush_ff && (fill_ff == imm_pkg::FILL_W'(1));
      fill_e     = fill_ff - imm_pkg::FILL_W'(emit);
      req_ready  = (fill_e < len_eff) && (!flush_ff || (fill_e == '0));
      accept     = req_valid && req_ready;
      fill_n     = fill_e + imm_pkg::FILL_W'(1);

      ctl.emit     = emit;
      ctl.load     = accept;
      ctl.pos      = fill_e[imm_pkg::CELL_IDX_W-1:0];
      ctl.start    = imm_pkg::CELL_IDX_W'(fill_n - len_eff);
      ctl.match_en = (fill_n >= len_eff);
      ctl.sym      = req_symbol;

      hit = accept && ctl.match_en && ((&fwd_ok) || (rc_en_ff && (&rc_ok)));

      fill_in  = accept ? fill_n : fill_e;
      flush_in = (accept && req_last) ? 1'b1 : (final_emit ? 1'b0 : flush_ff);
      armed_in = accept ? (!req_last && ctl.match_en) : (emit ? 1'b0 : armed_ff);
      found_in = (final_emit ? 1'b0 : found_ff) | hit;

      rsp_valid_in  = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      out_symbol_in = out_symbol_ff;
      masked_in     = masked_ff;
      out_last_in   = out_last_ff;
      any_masked_in = any_masked_ff;
      if (emit) begin
         out_symbol_in = cur_mask[0] ? mask_code_ff : cur_sym[0];
         masked_in     = cur_mask[0];
         out_last_in   = final_emit;
         any_masked_in = final_emit && found_ff;
      end
   end

   // window row, cell 0 holds the oldest entry
   for (genvar i = 0; i < N; i++) begin : g_cell
      logic [imm_pkg::SYM_W-1:0] nxt_sym;
      logic                      nxt_mask;
      if (i == N - 1) begin : g_end
         assign nxt_sym  = '0;
         assign nxt_mask = 1'b0;
      end else begin : g_mid
         assign nxt_sym  = cur_sym[i+1];
         assign nxt_mask = cur_mask[i+1];
      end
      imm_cell u_cell (
         .clock     (clock),
         .cell_idx  (imm_pkg::CELL_IDX_W'(i)),
         .ctl       (ctl),
         .motif     (motif_ff),
         .hit       (hit),
         .next_sym  (nxt_sym),
         .next_mask (nxt_mask),
         .cur_sym   (cur_sym[i]),
         .cur_mask  (cur_mask[i]),
         .fwd_ok    (fwd_ok[i]),
         .rc_ok     (rc_ok[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motif_ff     <= '0;
         len_ff       <= imm_pkg::LEN_W'(1);
         rc_en_ff     <= 1'b0;
         mask_code_ff <= '0;
         fill_ff      <= '0;
         flush_ff     <= 1'b0;
         armed_ff     <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         motif_ff     <= motif_in;
         len_ff       <= len_in;
         rc_en_ff     <= rc_en_in;
         mask_code_ff <= mask_code_in;
         fill_ff      <= fill_in;
         flush_ff     <= flush_in;
         armed_ff     <= armed_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_symbol_ff <= out_symbol_in;
      masked_ff     <= masked_in;
      out_last_ff   <= out_last_in;
      any_masked_ff <= any_masked_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_symbol = out_symbol_ff;
   assign rsp_masked     = masked_ff;
   assign rsp_out_last   = out_last_ff;
   assign rsp_any_masked = any_masked_ff;

endmodule

>>> rtl/imm_cell.sv
`timescale 1ns / 1ps
// One window position: holds a symbol and its mask bit, shifts toward cell 0.
// Depends on imm_pkg.
module imm_cell (
   input  logic                            clock,
   input  logic [imm_pkg::CELL_IDX_W-1:0]  cell_idx,
   input  imm_pkg::imm_ctl_type            ctl,
   input  logic [imm_pkg::MOTIF_W-1:0]     motif,
   input  logic                            hit,
   input  logic [imm_pkg::SYM_W-1:0]       next_sym,
   input  logic                            next_mask,
   output logic [imm_pkg::SYM_W-1:0]       cur_sym,
   output logic                            cur_mask,
   output logic                            fwd_ok,
   output logic                            rc_ok
);

   logic [imm_pkg::SYM_W-1:0]      sym_ff, sym_in;
   logic                           mask_ff, mask_in;
   logic [imm_pkg::SYM_W-1:0]      view_sym;
   logic                           view_mask;
   logic                           here;
   logic                           in_range;
   logic [imm_pkg::CELL_IDX_W-1:0] fwd_j;
   logic [imm_pkg::CELL_IDX_W-1:0] rc_k;
   logic [imm_pkg::SYM_W-1:0]      fwd_m;
   logic [imm_pkg::SYM_W-1:0]      rc_m;

   always_comb begin
      view_sym  = ctl.emit ? next_sym  : sym_ff;
      view_mask = ctl.emit ? next_mask : mask_ff;
      here      = ctl.load && (cell_idx == ctl.pos);
      sym_in    = here ? ctl.sym : view_sym;
      in_range  = ctl.load && ctl.match_en && (cell_idx >= ctl.start) && (cell_idx <= ctl.pos);
      // motif position seen by this cell, forward and reverse complement
      fwd_j     = cell_idx - ctl.start;
      rc_k      = ctl.pos - cell_idx;
      fwd_m     = motif[{fwd_j, 2'b00} +: imm_pkg::SYM_W];
      rc_m      = imm_pkg::complement(motif[{rc_k, 2'b00} +: imm_pkg::SYM_W]);
      fwd_ok    = !in_range || imm_pkg::sym_match(sym_in, fwd_m);
      rc_ok     = !in_range || imm_pkg::sym_match(sym_in, rc_m);
      mask_in   = (here ? 1'b0 : view_mask) | (in_range & hit);
   end

   always_ff @(posedge clock) begin
      sym_ff  <= sym_in;
      mask_ff <= mask_in;
   end

   assign cur_sym  = sym_ff;
   assign cur_mask = mask_ff;

endmodule

>>> rtl/imm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for iupac_motif_masker, attached by the bind below.
// Depends on imm_pkg for field widths.
module imm_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [imm_pkg::SYM_W-1:0]       rsp_out_symbol,
   input  logic                            rsp_masked,
   input  logic                            rsp_out_last,
   input  logic                            rsp_any_masked
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_symbol) &&
      $stable(rsp_masked) && $stable(rsp_out_last) && $stable(rsp_any_masked))
      else $error("rsp item changed while stalled");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // the sequence summary only rides on the final item
   a_any_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_any_masked |-> rsp_out_last)
      else $error("any_masked outside final item");

   // a masked final item implies the sequence had a hit
   a_last_masked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_last && rsp_masked |-> rsp_any_masked)
      else $error("final item masked but any_masked low");

endmodule

bind iupac_motif_masker imm_checker u_imm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_symbol (rsp_out_symbol),
   .rsp_masked     (rsp_masked),
   .rsp_out_last   (rsp_out_last),
   .rsp_any_masked (rsp_any_masked)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for iupac_motif_masker: feeds base-set symbol streams and
// checks every emitted symbol against a built-in window predictor. Needs imm_pkg.
module tb_top;

   typedef struct packed {
      logic [imm_pkg::SYM_W-1:0] sym;
      logic                      last;
   } base_item_type;

   typedef struct packed {
      logic [imm_pkg::SYM_W-1:0] sym_out;
      logic                      hit;
      logic                      last;
      logic                      any_hit;
   } masked_item_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [imm_pkg::SYM_W-1:0]      req_symbol = '0;
   logic                           req_last = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [imm_pkg::SYM_W-1:0]      rsp_out_symbol;
   logic                           rsp_masked;
   logic                           rsp_out_last;
   logic                           rsp_any_masked;
   logic                           csr_wr_en = 1'b0;
   logic [imm_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [imm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // register copies for the predictor
   logic [imm_pkg::MOTIF_W-1:0]    motif_q = '0;
   logic [imm_pkg::LEN_W-1:0]      len_q = 5'd1;
   logic                           revcomp_q = 1'b0;
   logic [imm_pkg::SYM_W-1:0]      mask_q = '0;

   // predictor window
   logic [imm_pkg::SYM_W-1:0]      win_sym [imm_pkg::MAX_MOTIF_LEN] = '{default: '0};
   logic                           win_mark [imm_pkg::MAX_MOTIF_LEN] = '{default: 1'b0};
   int                             win_fill = 0;
   logic                           seq_found = 1'b0;

   base_item_type                  feed_q [$];
   masked_item_type                out_q [$];
   int                             fail_count = 0;
   int                             send_idle_pct = 0;
   int                             recv_idle_pct = 0;
   logic                           pressure_on = 1'b0;
   logic                           hold_done = 1'b0;
   int                             hold_left = 0;

   iupac_motif_masker uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_symbol     (req_symbol),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_symbol (rsp_out_symbol),
      .rsp_masked     (rsp_masked),
      .rsp_out_last   (rsp_out_last),
      .rsp_any_masked (rsp_any_masked),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // motif length in use; out-of-range lengths are clamped
   function automatic int eff_span();
      if (len_q == 0) return 1;
      if (len_q > imm_pkg::MAX_MOTIF_LEN) return imm_pkg::MAX_MOTIF_LEN;
      return int'(len_q);
   endfunction

   function automatic bit window_hits(input int base, input int span, input bit rev);
      logic [imm_pkg::SYM_W-1:0] m;
      logic [imm_pkg::SYM_W-1:0] s;
      for (int i = 0; i < span; i++) begin
         m = rev ? motif_q[4*(span-1-i) +: 4] : motif_q[4*i +: 4];
         if (rev) m = {m[0], m[1], m[2], m[3]};
         s = win_sym[(base + i) % imm_pkg::MAX_MOTIF_LEN];
         if (s == '0 || (s & ~m) != '0) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic shift_oldest(input bit fin);
      masked_item_type r;
      r.sym_out = win_mark[0] ? mask_q : win_sym[0];
      r.hit = win_mark[0];
      r.last = fin;
      r.any_hit = fin & seq_found;
      out_q.push_back(r);
      for (int i = 0; i < imm_pkg::MAX_MOTIF_LEN - 1; i++) begin
         win_sym[i] = win_sym[i+1];
         win_mark[i] = win_mark[i+1];
      end
      win_sym[imm_pkg::MAX_MOTIF_LEN-1] = '0;
      win_mark[imm_pkg::MAX_MOTIF_LEN-1] = 1'b0;
      win_fill--;
   endtask

   task automatic predict_mask(input logic [imm_pkg::SYM_W-1:0] sym, input logic last_in);
      int span;
      int base;
      bit hit;
      span = eff_span();
      if (win_fill >= imm_pkg::MAX_MOTIF_LEN) win_fill = imm_pkg::MAX_MOTIF_LEN - 1;
      win_sym[win_fill] = sym;
      win_mark[win_fill] = 1'b0;
      win_fill++;
      if (win_fill >= span) begin
         base = win_fill - span;
         hit = window_hits(base, span, 1'b0);
         if (!hit && revcomp_q) hit = window_hits(base, span, 1'b1);
         if (hit) begin
            for (int i = 0; i < span; i++)
               win_mark[(base + i) % imm_pkg::MAX_MOTIF_LEN] = 1'b1;
            seq_found = 1'b1;
         end
      end
      if (last_in) begin
         while (win_fill > 0) shift_oldest(win_fill == 1);
         for (int i = 0; i < imm_pkg::MAX_MOTIF_LEN; i++) begin
            win_sym[i] = '0;
            win_mark[i] = 1'b0;
         end
         seq_found = 1'b0;
      end else begin
         while (win_fill >= span) shift_oldest(1'b0);
      end
   endtask

   // back-to-back writes keep the enable high, one assignment per edge
   task automatic apply_config(input logic [imm_pkg::MOTIF_W-1:0] motif,
                               input logic [imm_pkg::LEN_W-1:0] len,
                               input logic rc, input logic [imm_pkg::SYM_W-1:0] code);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= imm_pkg::CSR_MOTIF_SYMBOLS;
      csr_wdata <= motif;
      @(posedge clock);
      csr_index <= imm_pkg::CSR_MOTIF_LENGTH;
      csr_wdata <= imm_pkg::CSR_DATA_W'(len);
      @(posedge clock);
      csr_index <= imm_pkg::CSR_REVCOMP_ENABLE;
      csr_wdata <= imm_pkg::CSR_DATA_W'(rc);
      @(posedge clock);
      csr_index <= imm_pkg::CSR_MASK_CODE;
      csr_wdata <= imm_pkg::CSR_DATA_W'(code);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      motif_q = motif;
      len_q = len;
      revcomp_q = rc;
      mask_q = code;
   endtask

   task automatic pick_config(input int force_len);
      logic [imm_pkg::LEN_W-1:0] len;
      case ($urandom_range(9))
         0: len = ($urandom_range(1) == 0) ? 5'd0 : imm_pkg::LEN_W'($urandom_range(17, 31));
         1: len = 5'd16;
         default: len = imm_pkg::LEN_W'($urandom_range(1, 6));
      endcase
      if (force_len != 0) len = imm_pkg::LEN_W'(force_len);
      apply_config({$urandom, $urandom}, len, 1'($urandom_range(1)),
                   imm_pkg::SYM_W'($urandom_range(15)));
   endtask

   // sequences with planted motif copies (forward or reverse), some broken, rest noise
   task automatic queue_stream(input int count);
      int left;
      int run;
      int k;
      int span;
      bit rev;
      logic [imm_pkg::SYM_W-1:0] m;
      logic [imm_pkg::SYM_W-1:0] s;
      left = count;
      span = eff_span();
      while (left > 0) begin
         run = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
         if (run > left) run = left;
         k = 0;
         while (k < run) begin
            if ($urandom_range(99) < 40 && k + span <= run) begin
               rev = 1'($urandom_range(1));
               for (int j = 0; j < span; j++) begin
                  m = rev ? motif_q[4*(span-1-j) +: 4] : motif_q[4*j +: 4];
                  if (rev) m = {m[0], m[1], m[2], m[3]};
                  s = m & imm_pkg::SYM_W'($urandom);
                  if (s == '0) s = m;
                  if (s == '0 || $urandom_range(15) == 0)
                     s = imm_pkg::SYM_W'($urandom_range(15));
                  feed_q.push_back('{s, k == run - 1});
                  k++;
               end
            end else begin
               feed_q.push_back('{imm_pkg::SYM_W'($urandom_range(15)), k == run - 1});
               k++;
            end
         end
         left -= run;
      end
   endtask

   // sampled away from the rising edge so driver and monitor updates have settled
   task automatic drain();
      while (feed_q.size() != 0 || req_valid || out_q.size() != 0) @(negedge clock);
      repeat (40) @(posedge clock);
   endtask

   always @(posedge clock) begin : drive
      base_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = feed_q.pop_front();
            req_valid <= 1'b1;
            req_symbol <= nxt.sym;
            req_last <= nxt.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, once, while the sender keeps offering
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (pressure_on && !hold_done) begin
         hold_left <= 300;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : watch
      masked_item_type got;
      masked_item_type want;
      if (!reset) begin
         if (req_valid && req_ready) predict_mask(req_symbol, req_last);
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_out_symbol, rsp_masked, rsp_out_last, rsp_any_masked};
            if (out_q.size() == 0) begin
               $display("%0t: unexpected item: expected none, got sym=%h m=%b l=%b a=%b",
                        $time, got.sym_out, got.hit, got.last, got.any_hit);
               fail_count++;
            end else begin
               want = out_q.pop_front();
               if (got.sym_out !== want.sym_out || got.hit !== want.hit ||
                   got.last !== want.last || got.any_hit !== want.any_hit) begin
                  $display("%0t: mismatch: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                           $time, want.sym_out, want.hit, want.last, want.any_hit,
                           got.sym_out, got.hit, got.last, got.any_hit);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      int ph;
      int cfg;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      // reset registers: an empty motif position matches nothing
      feed_q.push_back('{4'hF, 1'b1});
      drain();

      // zero length taken as one, empty symbol never matches
      apply_config(64'h000000000000000F, 5'd0, 1'b0, 4'hF);
      feed_q.push_back('{4'h0, 1'b0});
      feed_q.push_back('{4'h1, 1'b0});
      feed_q.push_back('{4'h8, 1'b1});
      drain();

      // ACG forward and CGT reverse overlap, then a sequence shorter than the motif
      apply_config(64'h0000000000000421, 5'd3, 1'b1, 4'h0);
      feed_q.push_back('{4'h1, 1'b0});
      feed_q.push_back('{4'h2, 1'b0});
      feed_q.push_back('{4'h4, 1'b0});
      feed_q.push_back('{4'h8, 1'b1});
      feed_q.push_back('{4'h1, 1'b0});
      feed_q.push_back('{4'h2, 1'b1});
      drain();

      // length above the maximum, all-N motif
      apply_config({imm_pkg::MOTIF_W{1'b1}}, 5'd31, 1'b0, 4'h5);
      for (int i = 0; i < imm_pkg::MAX_MOTIF_LEN; i++)
         feed_q.push_back('{imm_pkg::SYM_W'((i % 15) + 1), i == imm_pkg::MAX_MOTIF_LEN - 1});
      drain();

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct <= 0;
               recv_idle_pct <= 0;
            end
            1: begin
               send_idle_pct <= 51;
               recv_idle_pct <= 0;
            end
            2: begin
               send_idle_pct <= 0;
               recv_idle_pct <= 51;
            end
            default: begin
               send_idle_pct <= 17;
               recv_idle_pct <= 17;
            end
         endcase
         for (cfg = 0; cfg < 3; cfg++) begin
            if (ph == 0 && cfg == 0) begin
               pick_config(16);
               pressure_on <= 1'b1;
               queue_stream(24);
            end else begin
               pick_config(0);
               queue_stream(14);
            end
            drain();
         end
      end

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
